### rtl/s5p_pkg.sv
// shared types and codes for the socks5 request header parser
`default_nettype none

package s5p_pkg;

  // protocol bytes
  localparam logic [7:0] SOCKS_VERSION = 8'h05;
  localparam logic [7:0] CMD_CONNECT   = 8'h01;
  localparam logic [7:0] ATYP_IPV4     = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
  localparam logic [7:0] ATYP_IPV6     = 8'h04;
  localparam logic [7:0] IPV4_LEN      = 8'd4;
  localparam logic [7:0] IPV6_LEN      = 8'd16;
  localparam logic [8:0] HOST_CAP_RST  = 9'd256;

  // parser phase
  typedef enum logic [2:0] {
    PH_VER  = 3'd0,
    PH_CMD  = 3'd1,
    PH_RSV  = 3'd2,
    PH_ATYP = 3'd3,
    PH_DLEN = 3'd4,
    PH_ADDR = 3'd5,
    PH_PHI  = 3'd6,
    PH_PLO  = 3'd7
  } phase_t;

  // result kind
  localparam logic [1:0] KIND_ADDR   = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // address type codes
  localparam logic [1:0] TYPE_IPV4   = 2'd0;
  localparam logic [1:0] TYPE_DOMAIN = 2'd1;
  localparam logic [1:0] TYPE_IPV6   = 2'd2;

  // error kinds
  localparam logic [1:0] ERR_GENERAL = 2'd0;
  localparam logic [1:0] ERR_CMD     = 2'd1;
  localparam logic [1:0] ERR_ATYP    = 2'd2;

  // one input item
  typedef struct packed {
    logic       restart;
    logic [7:0] rx_byte;
  } item_t;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  addr_byte;
    logic [7:0]  addr_index;
    logic [1:0]  addr_type;
    logic [7:0]  addr_length;
    logic [15:0] dest_port;
    logic [1:0]  error_kind;
  } result_t;

  // handshake between the parse stage and the input register
  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctl_t;

endpackage

`default_nettype wire

### rtl/socks5_request_header_parser.sv
// top level of the socks5 request header parser
//
// Usage:
//   in_*  : one request byte per item; in_tdata[7:0] is the byte and
//           in_tuser[0] forces it to be taken as the version byte of a new
//           request.
//   out_* : zero or one result per input byte; out_tuser holds the kind
//           (address byte, request complete, request rejected), out_tdata
//           the address byte and index, type, length, port and error kind.
//   cfg_* : write of the 9-bit host capacity; always ready. The user must
//           see it written while idle; the block does not enforce this.
// Path: an accepted byte sits in the input register and is decoded into the
//   result register once that register has room for a result.
// Throughput: one byte per cycle while results have room; the per-byte state
//   update is a single decode step from the input to the result register.
// Reset: synchronous, active low; the parser waits for a version byte and
//   the host capacity returns to 256.
// Stall: while out_tready is low the result register holds its item; the
//   input register still takes a byte, and further bytes wait only when a
//   held byte has a result with no place to go.
`default_nettype none

module socks5_request_header_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  in_tuser,   // [0] restart
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [7:0] addr_byte, [15:8] addr_index,
                                       // [17:16] addr_type, [25:18] addr_length,
                                       // [41:26] dest_port, [43:42] error_kind
  output logic [1:0]       out_tuser,  // [1:0] kind
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data
);
  import s5p_pkg::*;

  item_t      in_item, hold_item;
  logic       hold_valid;
  stage_ctl_t ctl;
  logic       res_valid;
  result_t    res, out_res;
  logic       room;

  assign in_item.rx_byte = in_tdata;
  assign in_item.restart = in_tuser[0];
  assign cfg_ready       = 1'b1;

  // input register
  s5p_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (ctl.take),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  // decode
  s5p_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .item_valid (hold_valid),
    .item       (hold_item),
    .out_room   (room),
    .ctl        (ctl),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register
  s5p_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_valid),
    .res        (res),
    .room       (room),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res)
  );

  // pack the result item
  assign out_tuser = out_res.kind;
  assign out_tdata = {4'b0000, out_res.error_kind, out_res.dest_port,
                      out_res.addr_length, out_res.addr_type,
                      out_res.addr_index, out_res.addr_byte};

endmodule

`default_nettype wire

### rtl/s5p_in_reg.sv
// input register stage holding one received item
`default_nettype none

module s5p_in_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire s5p_pkg::item_t in_item,
  input  wire logic          take,
  output logic               hold_valid,
  output s5p_pkg::item_t     hold_item
);
  import s5p_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  // room when empty or when the held item leaves this cycle
  assign in_ready  = !valid_r || take;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

`default_nettype wire

### rtl/s5p_parse.sv
// header state machine and per-byte decode
`default_nettype none

module s5p_parse (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [8:0]     cfg_data,
  input  wire logic           item_valid,
  input  wire s5p_pkg::item_t item,
  input  wire logic           out_room,
  output s5p_pkg::stage_ctl_t ctl,
  output logic                res_valid,
  output s5p_pkg::result_t    res
);
  import s5p_pkg::*;

  phase_t     phase_r, phase_nxt, ph;
  logic [1:0] type_held_r, type_held_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] addr_count_r, addr_count_nxt;
  logic [7:0] port_high_r, port_high_nxt;
  logic [8:0] host_cap_r;
  logic [7:0] b;
  logic       has_res;
  logic       take;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_cap_r <= HOST_CAP_RST;
    end else if (cfg_we) begin
      host_cap_r <= cfg_data;
    end
  end

  assign b  = item.rx_byte;
  assign ph = item.restart ? PH_VER : phase_r;

  // decode of the held byte
  always_comb begin
    phase_nxt      = ph;
    type_held_nxt  = type_held_r;
    bytes_left_nxt = bytes_left_r;
    addr_count_nxt = addr_count_r;
    port_high_nxt  = port_high_r;
    has_res        = 1'b0;
    res            = '0;
    case (ph)
      PH_VER: begin
        if (b == SOCKS_VERSION) begin
          phase_nxt = PH_CMD;
        end else begin
          has_res        = 1'b1;
          res.kind       = KIND_REJECT;
          res.error_kind = ERR_GENERAL;
        end
      end
      PH_CMD: begin
        if (b == CMD_CONNECT) begin
          phase_nxt = PH_RSV;
        end else begin
          phase_nxt      = PH_VER;
          has_res        = 1'b1;
          res.kind       = KIND_REJECT;
          res.error_kind = ERR_CMD;
        end
      end
      PH_RSV: begin
        phase_nxt = PH_ATYP;
      end
      PH_ATYP: begin
        addr_count_nxt = '0;
        if (b == ATYP_IPV4) begin
          type_held_nxt  = TYPE_IPV4;
          bytes_left_nxt = IPV4_LEN;
          phase_nxt      = PH_ADDR;
        end else if (b == ATYP_DOMAIN) begin
          type_held_nxt = TYPE_DOMAIN;
          phase_nxt     = PH_DLEN;
        end else if (b == ATYP_IPV6) begin
          type_held_nxt  = TYPE_IPV6;
          bytes_left_nxt = IPV6_LEN;
          phase_nxt      = PH_ADDR;
        end else begin
          phase_nxt      = PH_VER;
          has_res        = 1'b1;
          res.kind       = KIND_REJECT;
          res.error_kind = ERR_ATYP;
        end
      end
      PH_DLEN: begin
        if ({1'b0, b} >= host_cap_r) begin
          phase_nxt      = PH_VER;
          has_res        = 1'b1;
          res.kind       = KIND_REJECT;
          res.error_kind = ERR_GENERAL;
        end else begin
          bytes_left_nxt = b;
          phase_nxt      = (b == 8'd0) ? PH_PHI : PH_ADDR;
        end
      end
      PH_ADDR: begin
        has_res        = 1'b1;
        res.kind       = KIND_ADDR;
        res.addr_byte  = b;
        res.addr_index = addr_count_r;
        res.addr_type  = type_held_r;
        addr_count_nxt = addr_count_r + 8'd1;
        bytes_left_nxt = bytes_left_r - 8'd1;
        if (bytes_left_r == 8'd1) begin
          phase_nxt = PH_PHI;
        end
      end
      PH_PHI: begin
        port_high_nxt = b;
        phase_nxt     = PH_PLO;
      end
      PH_PLO: begin
        phase_nxt       = PH_VER;
        has_res         = 1'b1;
        res.kind        = KIND_DONE;
        res.addr_type   = type_held_r;
        res.addr_length = addr_count_r;
        res.dest_port   = {port_high_r, b};
      end
      default: begin
        phase_nxt = PH_VER;
      end
    endcase
  end

  // the item leaves when its result, if any, has a place to go
  assign take      = item_valid && (!has_res || out_room);
  assign res_valid = take && has_res;
  assign ctl.valid = item_valid;
  assign ctl.take  = take;

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_VER;
      type_held_r  <= '0;
      bytes_left_r <= '0;
      addr_count_r <= '0;
      port_high_r  <= '0;
    end else if (take) begin
      phase_r      <= phase_nxt;
      type_held_r  <= type_held_nxt;
      bytes_left_r <= bytes_left_nxt;
      addr_count_r <= addr_count_nxt;
      port_high_r  <= port_high_nxt;
    end
  end

`ifndef SYNTHESIS
  // address phase always has bytes still to come
  a_addr_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ADDR) |-> (bytes_left_r != 8'd0))
    else $error("address phase with no bytes left");

  // completion or rejection returns to the version byte
  a_done_ver: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.kind == KIND_DONE || res.kind == KIND_REJECT)) |=>
    (phase_r == PH_VER))
    else $error("parser not back at version byte after end of request");

  // held address type is one of the three decoded types
  a_type_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (type_held_r == TYPE_IPV4 || type_held_r == TYPE_DOMAIN ||
     type_held_r == TYPE_IPV6))
    else $error("bad held address type");

  // no item is consumed while nothing is held
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.take |-> ctl.valid)
    else $error("item taken with no item held");
`endif

endmodule

`default_nettype wire

### rtl/s5p_out_reg.sv
// result register toward the output channel
`default_nettype none

module s5p_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire s5p_pkg::result_t res,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output s5p_pkg::result_t      out_res
);
  import s5p_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  // free when empty or when the held result is taken this cycle
  assign room      = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : ((valid_r && out_ready) ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire
